/* rtl/fdtsp_pkg.sv */
// fdtsp_pkg: shared codes and types for the FDT structure block token parser.
// Used by fdtsp_decode and fdt_struct_token_parser; no dependencies.
package fdtsp_pkg;

    localparam int DEF_MAX_DEPTH = 64;
    localparam int SIZE_W        = 21;
    localparam int WORD_W        = 32;
    localparam int DEPTH_OUT_W   = 7;
    localparam int DEPTH_EXT_W   = 8;

    localparam logic [2:0] MODE_TOKEN = 3'd0;
    localparam logic [2:0] MODE_PLEN  = 3'd1;
    localparam logic [2:0] MODE_POFF  = 3'd2;
    localparam logic [2:0] MODE_NAME  = 3'd3;
    localparam logic [2:0] MODE_DATA  = 3'd4;

    localparam logic [2:0] EV_BEGIN    = 3'd0;
    localparam logic [2:0] EV_END_NODE = 3'd1;
    localparam logic [2:0] EV_PROP     = 3'd2;
    localparam logic [2:0] EV_NOP      = 3'd3;
    localparam logic [2:0] EV_END      = 3'd4;
    localparam logic [2:0] EV_NAME     = 3'd5;
    localparam logic [2:0] EV_DATA     = 3'd6;
    localparam logic [2:0] EV_ERROR    = 3'd7;

    localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
    localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
    localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;
    localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

    typedef struct packed {
        logic [2:0]        mode;
        logic [WORD_W-1:0] bytes_left;
        logic [WORD_W-1:0] held_length;
    } parse_state_t;

    typedef struct packed {
        logic              has_result;
        logic              halt;
        logic [2:0]        event_res;
        logic [WORD_W-1:0] payload;
        logic [WORD_W-1:0] prop_length;
        logic [WORD_W-1:0] name_offset;
        logic [2:0]        valid_bytes;
        logic              run_last;
    } parse_result_t;

endpackage

/* rtl/fdtsp_decode.sv */
// fdtsp_decode: combinational per-word step of the structure block parser.
// Depends on fdtsp_pkg for mode/event/token codes and state/result structs.
module fdtsp_decode
    import fdtsp_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
    input  logic [WORD_W-1:0]  word,
    input  parse_state_t       state_cur,
    input  logic [DEPTH_W-1:0] depth_cur,
    output parse_state_t       state_nxt,
    output logic [DEPTH_W-1:0] depth_nxt,
    output logic [DEPTH_W-1:0] depth_report,
    output parse_result_t      res
);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    logic                zero_byte;
    logic [2:0]          vb;
    logic [WORD_W-1:0]   left_after;

    assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                       (word[15:8] == 8'd0)  || (word[7:0] == 8'd0);
    assign vb         = (state_cur.bytes_left < 32'd4) ? state_cur.bytes_left[2:0] : 3'd4;
    assign left_after = state_cur.bytes_left - WORD_W'(vb);

    always_comb begin
        state_nxt    = state_cur;
        depth_nxt    = depth_cur;
        depth_report = depth_cur;
        res          = '0;
        case (state_cur.mode)
            MODE_PLEN: begin
                state_nxt.held_length = word;
                state_nxt.mode        = MODE_POFF;
            end
            MODE_POFF: begin
                res.has_result       = 1'b1;
                res.event_res        = EV_PROP;
                res.prop_length      = state_cur.held_length;
                res.name_offset      = word;
                state_nxt.bytes_left = state_cur.held_length;
                state_nxt.mode       = (state_cur.held_length == '0) ? MODE_TOKEN : MODE_DATA;
            end
            MODE_NAME: begin
                res.has_result = 1'b1;
                res.event_res  = EV_NAME;
                res.payload    = word;
                res.run_last   = zero_byte;
                if (zero_byte) begin
                    state_nxt.mode = MODE_TOKEN;
                end
            end
            MODE_DATA: begin
                res.has_result       = 1'b1;
                res.event_res        = EV_DATA;
                res.payload          = word;
                res.valid_bytes      = vb;
                res.run_last         = (left_after == '0);
                state_nxt.bytes_left = left_after;
                if (left_after == '0) begin
                    state_nxt.mode = MODE_TOKEN;
                end
            end
            default: begin
                state_nxt.mode = MODE_TOKEN;
                res.has_result = 1'b1;
                case (word)
                    TOK_BEGIN_NODE: begin
                        res.event_res  = EV_BEGIN;
                        state_nxt.mode = MODE_NAME;
                        if (depth_cur < DEPTH_MAX) begin
                            depth_nxt = depth_cur + 1'b1;
                        end
                    end
                    TOK_END_NODE: begin
                        res.event_res = EV_END_NODE;
                        if (depth_cur != '0) begin
                            depth_nxt    = depth_cur - 1'b1;
                            depth_report = depth_cur - 1'b1;
                        end
                    end
                    TOK_PROP: begin
                        res.has_result = 1'b0;
                        state_nxt.mode = MODE_PLEN;
                    end
                    TOK_NOP: begin
                        res.event_res = EV_NOP;
                    end
                    TOK_END: begin
                        res.event_res = EV_END;
                    end
                    default: begin
                        res.event_res = EV_ERROR;
                        res.payload   = word;
                        res.halt      = 1'b1;
                    end
                endcase
            end
        endcase
    end

endmodule

/* rtl/fdt_struct_token_parser.sv */
// fdt_struct_token_parser: FDT structure block parser, one word per transaction.
// Depends on fdtsp_pkg and fdtsp_decode.
// An accepted word's event is registered onto the m_ channel in the next cycle.
// Throughput: one word per cycle; s_ready is high while output is free or taken.
// Reset (aresetn, synchronous, active low) clears the parse state, depth,
// word count, size register and halt flag; no clearing pass is needed.
module fdt_struct_token_parser
    import fdtsp_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [WORD_W-1:0]      s_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_event_res,
    output logic [WORD_W-1:0]      m_payload,
    output logic [WORD_W-1:0]      m_prop_length,
    output logic [WORD_W-1:0]      m_name_offset,
    output logic [2:0]             m_valid_bytes,
    output logic [DEPTH_OUT_W-1:0] m_nest_depth,
    output logic                   m_run_last
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  seen_reg, seen_next;
    logic               halted_reg, halted_next;
    parse_state_t       state_reg, state_next, state_dec;
    logic [DEPTH_W-1:0] depth_reg, depth_next, depth_dec, depth_rpt;
    parse_result_t      res;
    logic               s_fire, active;
    logic               m_valid_reg, m_valid_next;
    logic [DEPTH_EXT_W-1:0] depth_ext;

    logic [2:0]         ev_reg;
    logic [WORD_W-1:0]  pay_reg, plen_reg, noff_reg;
    logic [2:0]         vb_reg;
    logic [DEPTH_OUT_W-1:0] nd_reg;
    logic               last_reg;

    fdtsp_decode #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_decode (
        .word         (s_word),
        .state_cur    (state_reg),
        .depth_cur    (depth_reg),
        .state_nxt    (state_dec),
        .depth_nxt    (depth_dec),
        .depth_report (depth_rpt),
        .res          (res)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign active    = s_fire && !halted_reg && (seen_reg < size_reg);
    assign depth_ext = DEPTH_EXT_W'(depth_rpt);

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        seen_next    = seen_reg;
        halted_next  = halted_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (s_fire) begin
            m_valid_next = 1'b0;
        end
        if (active) begin
            state_next   = state_dec;
            depth_next   = depth_dec;
            seen_next    = seen_reg + 1'b1;
            halted_next  = res.halt;
            m_valid_next = res.has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= '0;
            seen_reg    <= '0;
            halted_reg  <= 1'b0;
            state_reg   <= '{mode: MODE_TOKEN, bytes_left: '0, held_length: '0};
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
            seen_reg    <= seen_next;
            halted_reg  <= halted_next;
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (active) begin
            ev_reg   <= res.event_res;
            pay_reg  <= res.payload;
            plen_reg <= res.prop_length;
            noff_reg <= res.name_offset;
            vb_reg   <= res.valid_bytes;
            nd_reg   <= depth_ext[DEPTH_OUT_W-1:0];
            last_reg <= res.run_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_res   = ev_reg;
    assign m_payload     = pay_reg;
    assign m_prop_length = plen_reg;
    assign m_name_offset = noff_reg;
    assign m_valid_bytes = vb_reg;
    assign m_nest_depth  = nd_reg;
    assign m_run_last    = last_reg;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_ERROR) |-> halted_reg)
        else $error("error event without halt");

    a_vb_data_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_DATA) |-> (m_valid_bytes == 3'd0))
        else $error("valid bytes on non-data event");

    a_last_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_run_last) |-> (m_event_res == EV_NAME || m_event_res == EV_DATA))
        else $error("run_last outside a name or data run");

    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(MAX_DEPTH))
        else $error("depth above limit");

endmodule

/* dv/fdt_struct_token_parser_test.sv */
`timescale 1ns / 100ps
// fdt_struct_token_parser_test: self-checking bench for the FDT structure block parser.
// Streams directed and random token sequences and checks each event against a local predictor.
// Depends on fdtsp_pkg and fdt_struct_token_parser.
module fdt_struct_token_parser_test;
    import fdtsp_pkg::*;

    localparam int DEPTH_LIMIT = DEF_MAX_DEPTH;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 48;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [2:0]             kind;
        logic [WORD_W-1:0]      payload;
        logic [WORD_W-1:0]      plen;
        logic [WORD_W-1:0]      noff;
        logic [2:0]             vbytes;
        logic [DEPTH_OUT_W-1:0] depth;
        logic                   last;
    } fdt_event_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [SIZE_W-1:0]      cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [WORD_W-1:0]      s_word    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [2:0]             m_event_res;
    logic [WORD_W-1:0]      m_payload;
    logic [WORD_W-1:0]      m_prop_length;
    logic [WORD_W-1:0]      m_name_offset;
    logic [2:0]             m_valid_bytes;
    logic [DEPTH_OUT_W-1:0] m_nest_depth;
    logic                   m_run_last;

    // parser state as predicted
    logic [2:0]        pmode           = MODE_TOKEN;
    logic [WORD_W-1:0] bytes_remaining = '0;
    logic [WORD_W-1:0] length_held     = '0;
    logic [SIZE_W-1:0] words_counted   = '0;
    logic [SIZE_W-1:0] size_limit      = '0;
    logic [7:0]        depth_now       = '0;
    logic              halted_flag     = 1'b0;

    fdt_event_t pending_events[$];
    fdt_event_t seen_event;
    fdt_event_t wanted_event;
    fdt_event_t predicted_event;

    int       mismatches  = 0;
    int       words_sent  = 0;
    int       burst_left  = 0;
    int       idle_cycles = 0;
    int       hold_left   = 0;
    bit       hold_req    = 1'b0;
    logic [9:0] pattern_cnt = '0;

    fdt_struct_token_parser #(
        .MAX_DEPTH(DEPTH_LIMIT)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_word       (s_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_res  (m_event_res),
        .m_payload    (m_payload),
        .m_prop_length(m_prop_length),
        .m_name_offset(m_name_offset),
        .m_valid_bytes(m_valid_bytes),
        .m_nest_depth (m_nest_depth),
        .m_run_last   (m_run_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Advances the predicted state by one word; returns 1 when an event is due.
    function automatic bit parse_word(input logic [WORD_W-1:0] w, output fdt_event_t ev);
        logic [WORD_W-1:0] take;
        ev = '0;
        if (halted_flag || words_counted >= size_limit) return 1'b0;
        words_counted = words_counted + 1'b1;
        ev.depth = depth_now[DEPTH_OUT_W-1:0];
        case (pmode)
            MODE_PLEN: begin
                length_held = w;
                pmode = MODE_POFF;
                return 1'b0;
            end
            MODE_POFF: begin
                ev.kind = EV_PROP;
                ev.plen = length_held;
                ev.noff = w;
                bytes_remaining = length_held;
                pmode = (length_held == 0) ? MODE_TOKEN : MODE_DATA;
                return 1'b1;
            end
            MODE_NAME: begin
                ev.kind = EV_NAME;
                ev.payload = w;
                ev.last = (w[31:24] == 0) || (w[23:16] == 0) || (w[15:8] == 0) || (w[7:0] == 0);
                if (ev.last) pmode = MODE_TOKEN;
                return 1'b1;
            end
            MODE_DATA: begin
                take = (bytes_remaining < 4) ? bytes_remaining : 32'd4;
                bytes_remaining = bytes_remaining - take;
                ev.kind = EV_DATA;
                ev.payload = w;
                ev.vbytes = take[2:0];
                ev.last = (bytes_remaining == 0);
                if (ev.last) pmode = MODE_TOKEN;
                return 1'b1;
            end
            default: ;
        endcase
        pmode = MODE_TOKEN;
        case (w)
            TOK_BEGIN_NODE: begin
                ev.kind = EV_BEGIN;
                if (depth_now < DEPTH_LIMIT) depth_now = depth_now + 1'b1;
                pmode = MODE_NAME;
            end
            TOK_END_NODE: begin
                if (depth_now > 0) depth_now = depth_now - 1'b1;
                ev.kind = EV_END_NODE;
                ev.depth = depth_now[DEPTH_OUT_W-1:0];
            end
            TOK_PROP: begin
                pmode = MODE_PLEN;
                return 1'b0;
            end
            TOK_NOP: ev.kind = EV_NOP;
            TOK_END: ev.kind = EV_END;
            default: begin
                ev.kind = EV_ERROR;
                ev.payload = w;
                halted_flag = 1'b1;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_event = {m_event_res, m_payload, m_prop_length, m_name_offset,
                              m_valid_bytes, m_nest_depth, m_run_last};
                if (pending_events.size() == 0) begin
                    report_mismatch("unexpected transaction, event_res",
                                    32'(seen_event.kind), '0);
                end else begin
                    wanted_event = pending_events.pop_front();
                    if (seen_event.kind !== wanted_event.kind)
                        report_mismatch("event_res", 32'(seen_event.kind),
                                        32'(wanted_event.kind));
                    if (seen_event.payload !== wanted_event.payload)
                        report_mismatch("payload", seen_event.payload, wanted_event.payload);
                    if (seen_event.plen !== wanted_event.plen)
                        report_mismatch("prop_length", seen_event.plen, wanted_event.plen);
                    if (seen_event.noff !== wanted_event.noff)
                        report_mismatch("name_offset", seen_event.noff, wanted_event.noff);
                    if (seen_event.vbytes !== wanted_event.vbytes)
                        report_mismatch("valid_bytes", 32'(seen_event.vbytes),
                                        32'(wanted_event.vbytes));
                    if (seen_event.depth !== wanted_event.depth)
                        report_mismatch("nest_depth", 32'(seen_event.depth),
                                        32'(wanted_event.depth));
                    if (seen_event.last !== wanted_event.last)
                        report_mismatch("run_last", 32'(seen_event.last),
                                        32'(wanted_event.last));
                end
            end
            if (s_valid && s_ready) begin
                if (parse_word(s_word, predicted_event)) pending_events.push_back(predicted_event);
            end
            if (cfg_valid && cfg_ready) size_limit = cfg_data;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[fdt_struct_token_parser] ERROR");
                $finish;
            end
        end
    end

    // receiver: long hold on request, otherwise a rotating stall pattern
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            pattern_cnt = pattern_cnt + 1'b1;
            case (pattern_cnt[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 1) == 1);
                2'd2: m_ready <= (pattern_cnt[1:0] == 2'd0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        burst_left--;
        words_sent++;
    endtask

    task automatic drain_parser();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain_parser();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_node(input int n_name);
        logic [WORD_W-1:0] w;
        int pos;
        send_word(TOK_BEGIN_NODE);
        for (int i = 0; i < n_name; i++) begin
            for (int b = 0; b < 4; b++) w[b*8 +: 8] = 8'($urandom_range(1, 255));
            if (i == n_name - 1) begin
                pos = $urandom_range(0, 3);
                w[pos*8 +: 8] = 8'h00;
                if ($urandom_range(0, 3) == 0) w = w & $urandom();
            end
            send_word(w);
        end
    endtask

    task automatic send_prop(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] offset);
        send_word(TOK_PROP);
        send_word(len);
        send_word(offset);
        for (int i = 0; i < (len + 3) / 4; i++) send_word($urandom());
    endtask

    task automatic run_random_tree(input int n_words);
        int first;
        int pick;
        int len;
        first = words_sent;
        while (words_sent - first < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                send_node($urandom_range(1, 4));
            end else if (pick < 38) begin
                send_word(TOK_END_NODE);
            end else if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
                send_prop(len, $urandom());
            end else if (pick < 80) begin
                send_word(TOK_NOP);
            end else if (pick < 84) begin
                send_word(TOK_END);
            end else if (pick < 86) begin
                hold_req = 1'b1;
            end else if (pick < 94) begin
                // token values landing in length, offset, data and name slots
                if ($urandom_range(0, 1) == 0) begin
                    send_word(TOK_PROP);
                    send_word(TOK_BEGIN_NODE);
                    send_word(TOK_END_NODE);
                    send_word(TOK_NOP);
                end else begin
                    send_word(TOK_BEGIN_NODE);
                    send_word(TOK_PROP);
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: send_word(TOK_END_NODE);
                    1: send_word(TOK_NOP);
                    default: send_word(TOK_END);
                endcase
            end
        end
    endtask

    task automatic test_size_gate();
        // size resets to zero, so nothing is parsed yet
        send_word(TOK_BEGIN_NODE);
        send_word(32'h6162_6300);
        send_word(TOK_NOP);
        write_size('0);
        send_word(TOK_END);
        send_word(TOK_NOP);
        write_size(words_counted + 21'd4);
        send_word(TOK_NOP);
        send_word(TOK_BEGIN_NODE);
        send_word(32'h6162_6300);
        send_word(TOK_END_NODE);
        send_word(TOK_NOP);
        send_word(TOK_END);
        // cut a property after its length word, then resume it
        write_size(words_counted + 21'd2);
        send_word(TOK_PROP);
        send_word(32'd8);
        send_word(32'h1234_5678);
        write_size(21'h10_0000);
        send_word(32'h0000_0010);
        send_word($urandom());
        send_word($urandom());
    endtask

    task automatic test_token_mix();
        send_word(TOK_END_NODE);
        send_word(TOK_BEGIN_NODE);
        send_word(32'hFFFF_FFFF);
        send_word(32'h00AB_CDEF);
        send_word(TOK_BEGIN_NODE);
        send_word(32'h4100_4243);
        send_word(TOK_BEGIN_NODE);
        send_word(32'h4142_0043);
        send_word(TOK_BEGIN_NODE);
        send_word(32'h4142_4300);
        send_prop(32'd0, 32'h0000_0000);
        send_prop(32'd3, 32'hFFFF_FFFF);
        send_prop(32'd5, 32'h0000_0004);
        send_word(TOK_NOP);
        send_word(TOK_END);
        repeat (4) send_word(TOK_END_NODE);
    endtask

    task automatic test_depth_limits();
        repeat (DEPTH_LIMIT + 2) begin
            send_word(TOK_BEGIN_NODE);
            send_word(32'h0000_0000);
        end
        send_prop(32'd4, 32'h0000_0020);
        repeat (DEPTH_LIMIT + 2) send_word(TOK_END_NODE);
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        burst_left = 200;
        run_random_tree(150);
    endtask

    task automatic test_random_stream();
        run_random_tree(600);
        write_size('1);
        run_random_tree(600);
    endtask

    task automatic test_halt_on_bad_token();
        logic [WORD_W-1:0] bad;
        bad = ($urandom_range(0, 1) == 0) ? 32'h0 : ($urandom() | 32'h10);
        send_word(bad);
        send_word(TOK_BEGIN_NODE);
        send_word(TOK_NOP);
        send_word(TOK_END);
        repeat (6) send_word($urandom());
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_size_gate();
        test_token_mix();
        test_depth_limits();
        test_output_stall();
        test_random_stream();
        test_halt_on_bad_token();
        drain_parser();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("[fdt_struct_token_parser] OK");
        end else begin
            $display("[fdt_struct_token_parser] ERROR");
        end
        $finish;
    end

endmodule
